[design/mvpm_pkg.sv]
// Shared types and constants for the multi-voice PCM mixer.
// No dependencies; imported by multi_voice_pcm_mixer, mix_scoreboard_pkg and tb.
`timescale 1ns / 1ps

package mvpm_pkg;

  // request action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  // output sample limits
  localparam logic signed [19:0] SMP_MAX = 20'sd32767;
  localparam logic signed [19:0] SMP_MIN = -20'sd32768;

  // bias that turns an arithmetic shift into truncation toward zero
  localparam logic signed [26:0] TRUNC_BIAS = 27'sd255;

  // one voice descriptor as held in the voice memory
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] pos;
    logic [16:0] len;
    logic [9:0]  gain;
  } voice_t;

endpackage

[design/multi_voice_pcm_mixer.sv]
// Multi-voice PCM mixer: top level with sequencer, voice memory and sample memory.
// Depends on mvpm_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one request: tick, write a
//   sample word, start a voice, or stop all voices. Each request returns
//   exactly one result on the output channel (out_valid / out_stall).
//   A write or stop goes straight to the done state. A start scans slots
//   from slot 0, one slot per cycle, and stops at the first free slot or
//   at the last slot when all slots are busy. A tick visits every slot once;
//   each playing voice goes in turn through the shared multiply/accumulate
//   path (voice read, sample read, multiply, add).
//   One request at a time; the next one is accepted the cycle after the
//   result is loaded into the output register.
//   in_stall is high from acceptance until the result is loaded into the
//   output register. If the receiver stalls, the finished result waits
//   in the sequencer and the output register holds its value.
//   Reset (rst_n low, synchronous) clears all active voices and any pending
//   result. Voice descriptors and sample words are not cleared; reading a
//   sample word that was never written gives an undefined value.
module multi_voice_pcm_mixer
  import mvpm_pkg::*;
#(
  parameter int NUM_VOICES       = 16,
  parameter int SAMPLE_ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [15:0]         in_address,
  input  logic signed [15:0]  in_sample_value,
  input  logic [16:0]         in_voice_len,
  input  logic [9:0]          in_gain,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_mixed_sample,
  output logic                out_voice_started,
  output logic [3:0]          out_voice_slot,
  output logic [4:0]          out_active_count
);

  localparam int IDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W     = $clog2(NUM_VOICES + 1);
  localparam int SUM_W     = (SAMPLE_ADDR_BITS > 18) ? SAMPLE_ADDR_BITS : 18;
  localparam int STORE_DEP = 1 << SAMPLE_ADDR_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TSCAN  = 3'd1;
  localparam logic [2:0] ST_TFETCH = 3'd2;
  localparam logic [2:0] ST_TMUL   = 3'd3;
  localparam logic [2:0] ST_TACC   = 3'd4;
  localparam logic [2:0] ST_SSCAN  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [NUM_VOICES-1:0]  active_r, active_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [15:0]     acc_r, acc_nxt;
  logic                   started_r, started_nxt;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [15:0]     out_mix_r;
  logic                   out_started_r;
  logic [3:0]             out_slot_r;
  logic [4:0]             out_cnt_r;
  logic signed [26:0]     prod_r, prod_nxt;
  voice_t                 req_r, req_nxt;

  // memories and their ports
  voice_t                 vmem [NUM_VOICES];
  voice_t                 vrd_r;
  voice_t                 vwr_data;
  logic                   vwr_en;
  logic [15:0]            smem [STORE_DEP];
  logic [15:0]            smp_r;
  logic                   swr_en;
  logic [SAMPLE_ADDR_BITS-1:0] swr_addr;
  logic [SAMPLE_ADDR_BITS-1:0] srd_addr;

  logic                   in_accept;
  logic                   out_load;
  logic                   last_slot;
  logic [SUM_W-1:0]       wr_addr_ext;
  logic [SUM_W-1:0]       rd_addr_ext;
  logic signed [26:0]     prod_biased;
  logic signed [18:0]     quot;
  logic signed [19:0]     sum_wide;
  logic [IDX_W+3:0]       slot_ext;
  logic [CNT_W+4:0]       cnt_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign last_slot = (idx_r == LAST_IDX);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // address arithmetic, wrapping at the store depth
  assign wr_addr_ext = SUM_W'(in_address);
  assign swr_addr    = wr_addr_ext[SAMPLE_ADDR_BITS-1:0];
  assign rd_addr_ext = SUM_W'(vrd_r.base) + SUM_W'(vrd_r.pos);
  assign srd_addr    = rd_addr_ext[SAMPLE_ADDR_BITS-1:0];

  // scaled product, truncated toward zero, then clamped add
  assign prod_biased = prod_r + (prod_r[26] ? TRUNC_BIAS : 27'sd0);
  assign quot        = 19'(prod_biased >>> 8);
  assign sum_wide    = 20'(acc_r) + 20'(quot);

  // result fields masked to the port widths
  assign slot_ext = {4'b0, slot_r};
  assign cnt_ext  = {5'b0, cnt_r};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    active_nxt  = active_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    started_nxt = started_r;
    slot_nxt    = slot_r;
    prod_nxt    = prod_r;
    req_nxt     = req_r;
    vwr_en      = 1'b0;
    vwr_data    = req_r;
    swr_en      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          acc_nxt     = 16'sd0;
          started_nxt = 1'b0;
          slot_nxt    = '0;
          idx_nxt     = '0;
          case (in_action)
            ACT_TICK:  state_nxt = ST_TSCAN;
            ACT_WRITE: begin
              swr_en    = 1'b1;
              state_nxt = ST_DONE;
            end
            ACT_START: begin
              req_nxt.base = in_address;
              req_nxt.pos  = 17'd0;
              req_nxt.len  = in_voice_len;
              req_nxt.gain = in_gain;
              state_nxt    = ST_SSCAN;
            end
            default: begin
              active_nxt = '0;
              cnt_nxt    = '0;
              state_nxt  = ST_DONE;
            end
          endcase
        end
      end

      // skip idle slots; an active slot gets its descriptor read
      ST_TSCAN: begin
        if (active_r[idx_r]) begin
          state_nxt = ST_TFETCH;
        end else if (last_slot) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // finished voice drops out, otherwise its sample is read
      ST_TFETCH: begin
        if (vrd_r.pos >= vrd_r.len) begin
          active_nxt[idx_r] = 1'b0;
          cnt_nxt           = cnt_r - CNT_W'(1);
          if (last_slot) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_TSCAN;
          end
        end else begin
          state_nxt = ST_TMUL;
        end
      end

      ST_TMUL: begin
        prod_nxt  = 27'($signed(smp_r)) * 27'($signed({1'b0, vrd_r.gain}));
        state_nxt = ST_TACC;
      end

      // accumulate with saturation, advance the play position
      ST_TACC: begin
        if (sum_wide > SMP_MAX) begin
          acc_nxt = 16'(SMP_MAX);
        end else if (sum_wide < SMP_MIN) begin
          acc_nxt = 16'(SMP_MIN);
        end else begin
          acc_nxt = 16'(sum_wide);
        end
        vwr_en       = 1'b1;
        vwr_data     = vrd_r;
        vwr_data.pos = vrd_r.pos + 17'd1;
        if (last_slot) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_TSCAN;
        end
      end

      // lowest free slot takes the new voice
      ST_SSCAN: begin
        if (!active_r[idx_r]) begin
          vwr_en            = 1'b1;
          active_nxt[idx_r] = 1'b1;
          cnt_nxt           = cnt_r + CNT_W'(1);
          started_nxt       = 1'b1;
          slot_nxt          = idx_r;
          state_nxt         = ST_DONE;
        end else if (last_slot) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    started_r <= started_nxt;
    slot_r    <= slot_nxt;
    prod_r    <= prod_nxt;
    req_r     <= req_nxt;
    if (out_load) begin
      out_mix_r     <= acc_r;
      out_started_r <= started_r;
      out_slot_r    <= slot_ext[3:0];
      out_cnt_r     <= cnt_ext[4:0];
    end
  end

  // voice memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vmem[idx_r] <= vwr_data;
    end
    vrd_r <= vmem[idx_r];
  end

  // sample memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (swr_en) begin
      smem[swr_addr] <= in_sample_value;
    end
    smp_r <= smem[srd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_mixed_sample  = out_mix_r;
  assign out_voice_started = out_started_r;
  assign out_voice_slot    = out_slot_r;
  assign out_active_count  = out_cnt_r;

  // running count tracks the active bits
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(active_r)))
    else $error("active count out of step with active bits");

  // a reported start names a slot that is now active
  a_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && started_r |-> active_r[slot_r])
    else $error("started voice slot is not active");

  // only a tick produces a nonzero mix
  a_mix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_action != ACT_TICK) |=> (acc_r == 16'sd0))
    else $error("non-tick request left a nonzero mix");

  // the slot index never leaves the voice range
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && (state_r != ST_DONE) |-> (idx_r <= LAST_IDX))
    else $error("slot index beyond last voice");

endmodule

[verif/mix_scoreboard_pkg.sv]
// Request/result types and the scoreboard for the multi-voice PCM mixer bench.
// Depends on mvpm_pkg for the action codes and the output sample limits.
`timescale 1ns / 1ps

package mix_scoreboard_pkg;
  import mvpm_pkg::*;

  localparam int VOICES      = 16;
  localparam int STORE_WORDS = 65536;

  // one request as driven on the input channel
  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [16:0]        voice_len;
    logic [9:0]         gain;
  } mix_req_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic signed [15:0] mixed;
    logic               started;
    logic [3:0]         slot;
    logic [4:0]         count;
  } mix_result_t;

  class mix_scoreboard;
    // mirror of the mixer's voice table and sample memory
    logic               active  [VOICES];
    logic [15:0]        base    [VOICES];
    logic [16:0]        pos     [VOICES];
    logic [16:0]        len     [VOICES];
    logic [9:0]         gain    [VOICES];
    logic signed [15:0] store   [STORE_WORDS];
    bit                 written [STORE_WORDS];

    mix_result_t awaited [$];
    int          errors;
    int          clipped_ticks;
    int          refused_starts;

    function new();
      clear_voices();
    endfunction

    function void clear_voices();
      foreach (active[v]) begin
        active[v] = 1'b0;
        base[v]   = '0;
        pos[v]    = '0;
        len[v]    = '0;
        gain[v]   = '0;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // First store word that the next tick would read before it was ever written.
    function bit next_unwritten(output logic [15:0] addr);
      addr = '0;
      for (int v = 0; v < VOICES; v++) begin
        if (active[v] && pos[v] < len[v]) begin
          addr = base[v] + pos[v][15:0];
          if (!written[addr]) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it causes.
    function void note_request(mix_req_t r);
      mix_result_t e;
      int          sum;
      int          prod;
      logic [15:0] a;
      bit          clipped;
      e = '0;
      case (r.action)
        ACT_TICK: begin
          sum     = 0;
          clipped = 1'b0;
          for (int v = 0; v < VOICES; v++) begin
            if (!active[v]) continue;
            // a finished voice drops out without adding anything
            if (pos[v] >= len[v]) begin
              active[v] = 1'b0;
              continue;
            end
            a    = base[v] + pos[v][15:0];
            // integer divide truncates toward zero, as the Q2.8 scaling wants
            prod = int'(store[a]) * int'(gain[v]) / 256;
            sum  = sum + prod;
            if (sum > SMP_MAX) begin
              sum     = SMP_MAX;
              clipped = 1'b1;
            end else if (sum < SMP_MIN) begin
              sum     = SMP_MIN;
              clipped = 1'b1;
            end
            pos[v] = pos[v] + 17'd1;
          end
          e.mixed = sum[15:0];
          if (clipped) clipped_ticks++;
        end
        ACT_WRITE: begin
          store[r.address]   = r.sample_value;
          written[r.address] = 1'b1;
        end
        ACT_START: begin
          // lowest free slot wins
          for (int v = 0; v < VOICES; v++) begin
            if (!active[v]) begin
              active[v] = 1'b1;
              base[v]   = r.address;
              pos[v]    = '0;
              len[v]    = r.voice_len;
              gain[v]   = r.gain;
              e.started = 1'b1;
              e.slot    = 4'(v);
              break;
            end
          end
          if (!e.started) refused_starts++;
        end
        default: clear_voices();
      endcase
      foreach (active[v]) if (active[v]) e.count++;
      awaited.push_back(e);
    endfunction

    // Compare one result with the oldest outstanding one.
    function void check_result(mix_result_t got);
      mix_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding: mixed %0d started %0d slot %0d count %0d",
                 $time, got.mixed, got.started, got.slot, got.count);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.mixed !== e.mixed) begin
        $display("%0t: mixed_sample expected %0d, got %0d", $time, e.mixed, got.mixed);
        errors++;
      end
      if (got.started !== e.started) begin
        $display("%0t: voice_started expected %0d, got %0d", $time, e.started, got.started);
        errors++;
      end
      if (got.slot !== e.slot) begin
        $display("%0t: voice_slot expected %0d, got %0d", $time, e.slot, got.slot);
        errors++;
      end
      if (got.count !== e.count) begin
        $display("%0t: active_count expected %0d, got %0d", $time, e.count, got.count);
        errors++;
      end
    endfunction
  endclass

endpackage

[verif/tb.sv]
// Bench top for multi_voice_pcm_mixer: drives requests, randomizes stalls, checks results.
// Depends on mvpm_pkg, mix_scoreboard_pkg and the mixer RTL.
`timescale 1ns / 1ps

module tb;
  import mvpm_pkg::*;
  import mix_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int TOTAL_REQUESTS = 800;
  localparam int DRAIN_CYCLES   = 80;

  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action         = ACT_TICK;
  logic [15:0]        in_address        = '0;
  logic signed [15:0] in_sample_value   = '0;
  logic [16:0]        in_voice_len      = '0;
  logic [9:0]         in_gain           = '0;
  logic               out_valid;
  logic               out_stall         = 1'b0;
  logic signed [15:0] out_mixed_sample;
  logic               out_voice_started;
  logic [3:0]         out_voice_slot;
  logic [4:0]         out_active_count;

  logic          calm = 1'b0;
  int            cycles = 0;
  int            sent [4];
  mix_scoreboard sb = new();

  multi_voice_pcm_mixer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_address        (in_address),
    .in_sample_value   (in_sample_value),
    .in_voice_len      (in_voice_len),
    .in_gain           (in_gain),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mixed_sample  (out_mixed_sample),
    .out_voice_started (out_voice_started),
    .out_voice_slot    (out_voice_slot),
    .out_active_count  (out_active_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // result side: check on accept, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_mixed_sample, out_voice_started, out_voice_slot, out_active_count});
    out_stall <= !calm && ($urandom_range(0, 99) < 31);
  end

  // requests of every kind accepted so far
  function automatic int total_sent();
    return sent[0] + sent[1] + sent[2] + sent[3];
  endfunction

  // random content for every field; callers override what the action uses
  function automatic mix_req_t noise();
    mix_req_t r;
    r.action       = 2'($urandom_range(0, 3));
    r.address      = 16'($urandom);
    r.sample_value = 16'($urandom);
    r.voice_len    = 17'($urandom_range(0, 65536));
    r.gain         = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] marks [5] = '{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001};
    if ($urandom_range(0, 99) < 70) return 16'($urandom);
    return marks[$urandom_range(0, 4)];
  endfunction

  // Present one request, hold it until accepted, then tell the scoreboard.
  task automatic send_request(input mix_req_t r);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= r.action;
    in_address      <= r.address;
    in_sample_value <= r.sample_value;
    in_voice_len    <= r.voice_len;
    in_gain         <= r.gain;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    sent[r.action]++;
  endtask

  task automatic do_write(input logic [15:0] addr, input logic signed [15:0] value);
    mix_req_t r;
    r              = noise();
    r.action       = ACT_WRITE;
    r.address      = addr;
    r.sample_value = value;
    send_request(r);
  endtask

  task automatic do_start(input logic [15:0] base, input logic [16:0] vlen,
                          input logic [9:0] vgain);
    mix_req_t r;
    r           = noise();
    r.action    = ACT_START;
    r.address   = base;
    r.voice_len = vlen;
    r.gain      = vgain;
    send_request(r);
  endtask

  task automatic do_stop();
    mix_req_t r;
    r        = noise();
    r.action = ACT_STOP;
    send_request(r);
  endtask

  // A tick only reads written words: fill any gap a playing voice is about to hit.
  task automatic do_tick();
    mix_req_t    r;
    logic [15:0] gap;
    while (sb.next_unwritten(gap)) do_write(gap, pick_sample());
    r        = noise();
    r.action = ACT_TICK;
    send_request(r);
  endtask

  initial begin
    int          pick;
    logic [15:0] addr;
    logic [16:0] vlen;
    logic [9:0]  vgain;
    logic [9:0]  gain_marks [5] = '{10'd0, 10'd1, 10'd255, 10'd256, 10'd1023};
    bit          paused = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty mix, wrap, both clip rails, truncation, zero length, full table
    do_tick();
    do_write(16'hFFFF, 16'sh8000);
    do_write(16'h0000, 16'sh7FFF);
    do_write(16'h0001, 16'shFFFF);
    do_write(16'h0002, 16'sh0155);
    do_start(16'hFFFF, 17'd3, 10'd1023);
    do_start(16'hFFFF, 17'd3, 10'd1023);
    do_start(16'h0001, 17'd1, 10'd1);     // -1 scaled by 1/256 must give 0, not -1
    do_start(16'h0000, 17'd0, 10'd256);   // zero length, dropped on the first tick
    repeat (12) do_start(16'h0000, 17'd65536, 10'd1023);
    do_start(16'h0003, 17'd5, 10'd256);   // every slot busy
    do_tick();
    do_tick();
    do_stop();
    do_tick();

    // random mix of writes, starts, ticks and stops; gap fills count as requests
    while (total_sent() < TOTAL_REQUESTS) begin
      calm <= (total_sent() >= 300 && total_sent() < 500);
      if (!paused && total_sent() >= 600) begin
        // hold off until every outstanding result is back
        paused   = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
        do_tick();
      end else if (pick < 62) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      addr = 16'($urandom_range(0, 511));
        else if (pick < 75) addr = 16'hFFFF - 16'($urandom_range(0, 63));
        else                addr = 16'($urandom);
        do_write(addr, pick_sample());
      end else if (pick < 97) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      addr = 16'($urandom_range(0, 463));
        else if (pick < 60) addr = 16'hFFFF - 16'($urandom_range(0, 40));
        else                addr = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)       vlen = 17'd0;
        else if (pick < 7)  vlen = 17'd65536;
        else if (pick < 10) vlen = 17'($urandom_range(0, 65536));
        else                vlen = 17'($urandom_range(1, 48));
        if ($urandom_range(0, 99) < 70) vgain = 10'($urandom_range(0, 1023));
        else                            vgain = gain_marks[$urandom_range(0, 4)];
        do_start(addr, vlen, vgain);
      end else begin
        do_stop();
      end
    end

    // drain
    in_valid <= 1'b0;
    calm     <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ticks (%0d clipped), %0d sample writes, %0d starts (%0d refused),",
             sent[ACT_TICK], sb.clipped_ticks, sent[ACT_WRITE], sent[ACT_START],
             sb.refused_starts);
    $display("and %0d stop-all requests; %0d mismatches", sent[ACT_STOP], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
